// File: hdl/rbm_pkg.sv
// Shared types and constants for the region block mosaic.
package rbm_pkg;
	localparam int ROW_W      = 11;
	localparam int BY_W       = 10;
	localparam int HEIGHT_CAP = 2048;
	localparam int CH_W       = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_X      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 3'd6;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} pix_t;
endpackage

// File: hdl/rbm_store.sv
// Band store: one band of pixels, synchronous read with a registered output.
module rbm_store #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  rbm_pkg::pix_t wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output rbm_pkg::pix_t rdata
);
	import rbm_pkg::*;

	pix_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// File: hdl/rbm_sums.sv
// Per-block channel sums for two alternating bands, synchronous read.
module rbm_sums #(
	parameter int AW = 11,
	parameter int DW = 54
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: hdl/rbm_div.sv
// Three-lane restoring divider with round-half-to-even on the quotient.
module rbm_div #(
	parameter int SW = 18,
	parameter int NW = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [2:0][SW-1:0]     dvd,
	input  logic [NW-1:0]          dvs,
	output logic                   done,
	output logic [2:0][rbm_pkg::CH_W-1:0] quo
);
	import rbm_pkg::*;

	localparam int CNT_W = $clog2(SW + 1);

	logic                busy_q;
	logic                rnd_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [NW-1:0]       d_q;
	logic [2:0][NW-1:0]  rem_q;
	logic [2:0][SW-1:0]  qt_q;
	logic [2:0][NW:0]    sh;
	logic [2:0]          ge;
	logic [2:0][NW:0]    twice;
	logic [2:0]          up;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh[i]    = {rem_q[i], qt_q[i][SW-1]};
			ge[i]    = sh[i] >= {1'b0, d_q};
			twice[i] = {rem_q[i], 1'b0};
			up[i]    = (twice[i] > {1'b0, d_q}) ||
			           ((twice[i] == {1'b0, d_q}) && qt_q[i][0]);
			quo[i]   = qt_q[i][CH_W-1:0] + CH_W'(up[i]);
		end
	end

	assign done = rnd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			rnd_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					rnd_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= dvs;
			rem_q <= '0;
			qt_q  <= dvd;
		end else if (busy_q) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= ge[i] ? NW'(sh[i] - {1'b0, d_q}) : NW'(sh[i]);
				qt_q[i]  <= {qt_q[i][SW-2:0], ge[i]};
			end
		end
	end
endmodule

// File: hdl/region_block_mosaic.sv
// Top level of the region block mosaic: sequencer, counters and memories.
// One transaction is in work at a time: accept, read, compare, write back, then output if it emits.
// A passed-through pixel goes from write-back straight to the output step; a mosaic
// pixel first waits on the serial divider in the divide step, then goes to the output step.
// Output is registered; a stalled output holds the sequencer.
// Reset clears counters and control; memories keep their contents and are not cleared.
module region_block_mosaic #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_BLOCK = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rbm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            op,
	input  logic [7:0]                      blue_in,
	input  logic [7:0]                      green_in,
	input  logic [7:0]                      red_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      blue_out,
	output logic [7:0]                      green_out,
	output logic [7:0]                      red_out,
	output logic                            frame_last
);
	import rbm_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int BSW   = $clog2(MAX_BLOCK + 1);
	localparam int MW    = $clog2(MAX_BLOCK);
	localparam int BXW   = $clog2(MAX_WIDTH / 2);
	localparam int SAW   = BXW + 1;
	localparam int STAW  = $clog2(MAX_WIDTH * MAX_BLOCK);
	localparam int SUM_W = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
	localparam int NW    = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
	localparam int PW    = ((CW > ROW_W) ? CW : ROW_W) + BSW + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_A    = 3'd1;
	localparam logic [2:0] ST_B    = 3'd2;
	localparam logic [2:0] ST_C    = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] state_q;

	logic [11:0] image_width_q, image_height_q, region_width_q, region_height_q;
	logic [10:0] region_x_q, region_y_q;
	logic [5:0]  block_size_q;

	logic [WW-1:0]  w_c;
	logic [11:0]    h_c;
	logic [BSW-1:0] bs_c;

	logic [CW-1:0]    in_col_q, out_col_q;
	logic [MW-1:0]    in_cm_q, in_rm_q, out_cm_q, out_rm_q;
	logic [BXW-1:0]   in_bx_q, out_bx_q;
	logic [ROW_W-1:0] in_row_q, out_row_q;
	logic [BY_W-1:0]  in_by_q, out_by_q;
	logic             done_q;

	logic      op_q, emit_q, last_q, reg_s2;
	pix_t      pin_q, pix_q, res_q, store_rd;
	logic [PW-1:0]  bxs_s1, bys_s1;
	logic [BSW-1:0] cols_s2, rows_s2;
	logic [3*SUM_W-1:0] esum_q, sums_rd, sums_wr;

	logic [STAW-1:0] e_off, i_off;
	logic [SAW-1:0]  sums_raddr;
	logic            emit_c, wr_en, div_start, div_done;
	logic [2:0][SUM_W-1:0] div_dvd;
	logic [2:0][CH_W-1:0]  div_quo;
	logic [NW-1:0]   n_c;
	logic [PW-1:0]   rx_end, ry_end, cdiff, rdiff;
	logic            col_in, row_in, first_c;
	logic [SUM_W-1:0] ob, og, orr;

	logic out_valid_q;
	logic out_load;
	pix_t out_q;
	logic out_last_q;

	always_comb begin
		if (image_width_q == '0)
			w_c = WW'(1);
		else if (32'(image_width_q) > MAX_WIDTH)
			w_c = WW'(MAX_WIDTH);
		else
			w_c = WW'(image_width_q);
		if (image_height_q == '0)
			h_c = 12'd1;
		else if (32'(image_height_q) > HEIGHT_CAP)
			h_c = 12'(HEIGHT_CAP);
		else
			h_c = image_height_q;
		if (block_size_q < 6'd2)
			bs_c = BSW'(2);
		else if (32'(block_size_q) > MAX_BLOCK)
			bs_c = BSW'(MAX_BLOCK);
		else
			bs_c = BSW'(block_size_q);
	end

	assign emit_c = (op_q == OP_DRAIN) ? done_q : (in_by_q != '0);
	assign e_off  = STAW'(STAW'(out_rm_q) * STAW'(w_c)) + STAW'(out_col_q);
	assign i_off  = STAW'(STAW'(in_rm_q) * STAW'(w_c)) + STAW'(in_col_q);
	assign sums_raddr = (state_q == ST_A) ? {out_by_q[0], out_bx_q} : {in_by_q[0], in_bx_q};
	assign wr_en  = (state_q == ST_C) && (op_q == OP_PIXEL);

	assign rx_end = PW'(region_x_q) + PW'(region_width_q);
	assign ry_end = PW'(region_y_q) + PW'(region_height_q);
	assign col_in = (region_width_q != '0) && (bxs_s1 < rx_end) &&
	                ((bxs_s1 + PW'(bs_c)) > PW'(region_x_q));
	assign row_in = (region_height_q != '0) && (bys_s1 < ry_end) &&
	                ((bys_s1 + PW'(bs_c)) > PW'(region_y_q));
	assign cdiff  = PW'(w_c) - bxs_s1;
	assign rdiff  = PW'(h_c) - bys_s1;
	assign n_c    = NW'(NW'(rows_s2) * NW'(cols_s2));

	assign first_c = (in_rm_q == '0) && (in_cm_q == '0);
	assign ob  = sums_rd[SUM_W-1:0];
	assign og  = sums_rd[2*SUM_W-1:SUM_W];
	assign orr = sums_rd[3*SUM_W-1:2*SUM_W];
	assign sums_wr = first_c ?
		{SUM_W'(pin_q.r), SUM_W'(pin_q.g), SUM_W'(pin_q.b)} :
		{orr + SUM_W'(pin_q.r), og + SUM_W'(pin_q.g), ob + SUM_W'(pin_q.b)};

	assign div_start = (state_q == ST_C) && emit_q && reg_s2;
	assign div_dvd   = {esum_q[3*SUM_W-1:2*SUM_W], esum_q[2*SUM_W-1:SUM_W],
	                    esum_q[SUM_W-1:0]};

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	rbm_store #(.DEPTH(MAX_WIDTH * MAX_BLOCK), .AW(STAW)) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (i_off),
		.wdata (pin_q),
		.re    (state_q == ST_A),
		.raddr (e_off),
		.rdata (store_rd)
	);

	rbm_sums #(.AW(SAW), .DW(3 * SUM_W)) u_sums (
		.clk   (clk),
		.we    (wr_en),
		.waddr ({in_by_q[0], in_bx_q}),
		.wdata (sums_wr),
		.raddr (sums_raddr),
		.rdata (sums_rd)
	);

	rbm_div #(.SW(SUM_W), .NW(NW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (div_dvd),
		.dvs    (n_c),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			image_width_q   <= 12'd640;
			image_height_q  <= 12'd480;
			region_x_q      <= '0;
			region_y_q      <= '0;
			region_width_q  <= '0;
			region_height_q <= '0;
			block_size_q    <= 6'd20;
			in_col_q <= '0; in_cm_q <= '0; in_bx_q <= '0;
			in_row_q <= '0; in_rm_q <= '0; in_by_q <= '0;
			out_col_q <= '0; out_cm_q <= '0; out_bx_q <= '0;
			out_row_q <= '0; out_rm_q <= '0; out_by_q <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_IMAGE_WIDTH:   image_width_q   <= cfg_data;
					CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_data;
					CFG_REGION_X:      region_x_q      <= cfg_data[10:0];
					CFG_REGION_Y:      region_y_q      <= cfg_data[10:0];
					CFG_REGION_WIDTH:  region_width_q  <= cfg_data;
					CFG_REGION_HEIGHT: region_height_q <= cfg_data;
					CFG_BLOCK_SIZE:    block_size_q    <= cfg_data[5:0];
					default: ;
				endcase
				if (cfg_index <= CFG_BLOCK_SIZE) begin
					in_col_q <= '0; in_cm_q <= '0; in_bx_q <= '0;
					in_row_q <= '0; in_rm_q <= '0; in_by_q <= '0;
					out_col_q <= '0; out_cm_q <= '0; out_bx_q <= '0;
					out_row_q <= '0; out_rm_q <= '0; out_by_q <= '0;
					done_q <= 1'b0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_A;
						if (op == OP_PIXEL && done_q) begin
							done_q <= 1'b0;
							out_col_q <= '0; out_cm_q <= '0; out_bx_q <= '0;
							out_row_q <= '0; out_rm_q <= '0; out_by_q <= '0;
						end
					end
				end
				ST_A: begin
					if (op_q == OP_DRAIN && !done_q)
						state_q <= ST_IDLE;
					else
						state_q <= ST_B;
				end
				ST_B: state_q <= ST_C;
				ST_C: begin
					if (op_q == OP_PIXEL) begin
						if ((WW'(in_col_q) + WW'(1)) == w_c) begin
							in_col_q <= '0; in_cm_q <= '0; in_bx_q <= '0;
							if ((12'(in_row_q) + 12'd1) == h_c) begin
								in_row_q <= '0; in_rm_q <= '0; in_by_q <= '0;
								done_q <= 1'b1;
							end else begin
								in_row_q <= in_row_q + ROW_W'(1);
								if ((BSW'(in_rm_q) + BSW'(1)) == bs_c) begin
									in_rm_q <= '0;
									in_by_q <= in_by_q + BY_W'(1);
								end else begin
									in_rm_q <= in_rm_q + MW'(1);
								end
							end
						end else begin
							in_col_q <= in_col_q + CW'(1);
							if ((BSW'(in_cm_q) + BSW'(1)) == bs_c) begin
								in_cm_q <= '0;
								in_bx_q <= in_bx_q + BXW'(1);
							end else begin
								in_cm_q <= in_cm_q + MW'(1);
							end
						end
					end
					if (!emit_q)
						state_q <= ST_IDLE;
					else if (reg_s2)
						state_q <= ST_DIV;
					else
						state_q <= ST_OUT;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						state_q     <= ST_IDLE;
						if (last_q) begin
							done_q <= 1'b0;
							out_col_q <= '0; out_cm_q <= '0; out_bx_q <= '0;
							out_row_q <= '0; out_rm_q <= '0; out_by_q <= '0;
						end else if ((WW'(out_col_q) + WW'(1)) == w_c) begin
							out_col_q <= '0; out_cm_q <= '0; out_bx_q <= '0;
							out_row_q <= out_row_q + ROW_W'(1);
							if ((BSW'(out_rm_q) + BSW'(1)) == bs_c) begin
								out_rm_q <= '0;
								out_by_q <= out_by_q + BY_W'(1);
							end else begin
								out_rm_q <= out_rm_q + MW'(1);
							end
						end else begin
							out_col_q <= out_col_q + CW'(1);
							if ((BSW'(out_cm_q) + BSW'(1)) == bs_c) begin
								out_cm_q <= '0;
								out_bx_q <= out_bx_q + BXW'(1);
							end else begin
								out_cm_q <= out_cm_q + MW'(1);
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q  <= op;
				pin_q <= '{r: red_in, g: green_in, b: blue_in};
			end
			ST_A: begin
				emit_q <= emit_c;
				bxs_s1 <= PW'(out_bx_q) * PW'(bs_c);
				bys_s1 <= PW'(out_by_q) * PW'(bs_c);
				last_q <= (12'(out_row_q) == h_c - 12'd1) &&
				          (WW'(out_col_q) == w_c - WW'(1));
			end
			ST_B: begin
				pix_q   <= store_rd;
				esum_q  <= sums_rd;
				reg_s2  <= col_in && row_in;
				cols_s2 <= (cdiff > PW'(bs_c)) ? bs_c : BSW'(cdiff);
				rows_s2 <= (rdiff > PW'(bs_c)) ? bs_c : BSW'(rdiff);
			end
			ST_C: res_q <= pix_q;
			ST_DIV: begin
				if (div_done)
					res_q <= '{r: div_quo[2], g: div_quo[1], b: div_quo[0]};
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_q      <= res_q;
					out_last_q <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign blue_out   = out_q.b;
	assign green_out  = out_q.g;
	assign red_out    = out_q.r;
	assign frame_last = out_last_q;

`ifndef SYNTHESIS
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("transaction accepted while another is in work");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("output raised outside the output step");
	a_div_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait step");
`endif
endmodule

// File: dv/tb.sv
// Self-checking testbench for the region block mosaic: directed frames, then random frames.
`timescale 1ns / 100ps

module tb;
	import rbm_pkg::*;

	typedef struct {
		logic [7:0] b, g, r;
		logic       last;
	} mosaic_px_t;

	typedef struct {
		logic       op;
		logic [7:0] b, g, r;
		bit         typed;
		mosaic_px_t want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  op = OP_PIXEL;
	logic [7:0]            blue_in = '0, green_in = '0, red_in = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            blue_out, green_out, red_out;
	logic                  frame_last;

	region_block_mosaic u_dut (.*);

	always #2 clk = ~clk;

	// predictor state
	int unsigned geo_reg[7];
	bit [23:0]   band_px[65536];
	int unsigned blk_sum[2][1024][3];
	int unsigned in_row, in_col, out_row, out_col;
	bit          frame_in_done;
	mosaic_px_t  pending_px[$];

	int  errors = 0;
	int  idle_mode = 0;
	int  sent = 0;

	function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic int unsigned round_even(int unsigned s, int unsigned n);
		int unsigned q, rem;
		q = s / n;
		rem = s - q * n;
		if (2 * rem > n || (2 * rem == n && q[0])) q++;
		return q & 8'hFF;
	endfunction

	function automatic bit blk_hit(int unsigned idx, int unsigned bs, int unsigned start,
			int unsigned len);
		return len != 0 && idx * bs < start + len && (idx + 1) * bs > start;
	endfunction

	function automatic void mosaic_emit();
		int unsigned w, h, bs, bx, by, cols, rows, n;
		bit [23:0]   px;
		mosaic_px_t  o;
		w = clampu(geo_reg[CFG_IMAGE_WIDTH], 1, 2048);
		h = clampu(geo_reg[CFG_IMAGE_HEIGHT], 1, 2048);
		bs = clampu(geo_reg[CFG_BLOCK_SIZE], 2, 32);
		px = band_px[(out_row % bs) * w + out_col];
		o.b = px[7:0];
		o.g = px[15:8];
		o.r = px[23:16];
		bx = out_col / bs;
		by = out_row / bs;
		if (blk_hit(bx, bs, geo_reg[CFG_REGION_X], geo_reg[CFG_REGION_WIDTH]) &&
				blk_hit(by, bs, geo_reg[CFG_REGION_Y], geo_reg[CFG_REGION_HEIGHT])) begin
			cols = clampu(w - bx * bs, 0, bs);
			rows = clampu(h - by * bs, 0, bs);
			n = rows * cols;
			o.b = round_even(blk_sum[by & 1][bx][0], n);
			o.g = round_even(blk_sum[by & 1][bx][1], n);
			o.r = round_even(blk_sum[by & 1][bx][2], n);
		end
		o.last = out_row == h - 1 && out_col == w - 1;
		pending_px.push_back(o);
		if (o.last) begin
			out_row = 0;
			out_col = 0;
			frame_in_done = 0;
		end else if (out_col + 1 >= w) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
	endfunction

	function automatic void mosaic_step(logic o_op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
		int unsigned w, h, bs, bx, k;
		w = clampu(geo_reg[CFG_IMAGE_WIDTH], 1, 2048);
		h = clampu(geo_reg[CFG_IMAGE_HEIGHT], 1, 2048);
		bs = clampu(geo_reg[CFG_BLOCK_SIZE], 2, 32);
		if (o_op == OP_DRAIN) begin
			if (frame_in_done) mosaic_emit();
			return;
		end
		if (frame_in_done) begin
			frame_in_done = 0;
			out_row = 0;
			out_col = 0;
		end
		if (in_row >= bs) mosaic_emit();
		band_px[(in_row % bs) * w + in_col] = {r, g, b};
		bx = in_col / bs;
		k = (in_row / bs) & 1;
		if (in_row % bs == 0 && in_col % bs == 0) begin
			blk_sum[k][bx][0] = b;
			blk_sum[k][bx][1] = g;
			blk_sum[k][bx][2] = r;
		end else begin
			blk_sum[k][bx][0] += b;
			blk_sum[k][bx][1] += g;
			blk_sum[k][bx][2] += r;
		end
		if (in_col + 1 >= w) begin
			in_col = 0;
			if (in_row + 1 >= h) begin
				in_row = 0;
				frame_in_done = 1;
			end else begin
				in_row++;
			end
		end else begin
			in_col++;
		end
	endfunction

	always @(posedge clk) begin
		case (idle_mode)
			2: out_stall <= $urandom_range(99) < 79;
			3: out_stall <= $urandom_range(99) < 25;
			default: out_stall <= 1'b0;
		endcase
	end

	always @(negedge clk) begin
		mosaic_px_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_px.size() == 0) begin
				$display("%0t: unexpected transaction, actual b=%0d g=%0d r=%0d last=%0b",
					$time, blue_out, green_out, red_out, frame_last);
				errors++;
			end else begin
				e = pending_px.pop_front();
				if (e.b !== blue_out || e.g !== green_out || e.r !== red_out ||
						e.last !== frame_last) begin
					$display("%0t: expected b=%0d g=%0d r=%0d last=%0b, actual b=%0d g=%0d r=%0d last=%0b",
						$time, e.b, e.g, e.r, e.last, blue_out, green_out, red_out,
						frame_last);
					errors++;
				end
			end
		end
	end

	task automatic send(logic o_op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
		bit acc;
		forever begin
			if ((idle_mode == 1 && $urandom_range(99) < 79) ||
					(idle_mode == 3 && $urandom_range(99) < 25)) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end else begin
				break;
			end
		end
		in_valid <= 1'b1;
		op <= o_op;
		blue_in <= b;
		green_in <= g;
		red_in <= r;
		forever begin
			@(negedge clk);
			acc = !in_stall;
			@(posedge clk);
			if (acc) break;
		end
		mosaic_step(o_op, b, g, r);
		sent++;
	endtask

	task automatic write_geometry(int unsigned v[7]);
		in_valid <= 1'b0;
		wait (pending_px.size() == 0);
		repeat (100) @(posedge clk);
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data <= v[i][CFG_DATA_W-1:0];
			@(posedge clk);
			case (i)
				CFG_REGION_X, CFG_REGION_Y: geo_reg[i] = v[i] & 12'h7FF;
				CFG_BLOCK_SIZE: geo_reg[i] = v[i] & 6'h3F;
				default: geo_reg[i] = v[i] & 12'hFFF;
			endcase
			in_row = 0;
			in_col = 0;
			out_row = 0;
			out_col = 0;
			frame_in_done = 0;
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_frame(bit cut_drain, bit noise, int unsigned cap = 32'hFFFF_FFFF);
		int unsigned n, k;
		n = clampu(geo_reg[CFG_IMAGE_WIDTH], 1, 2048) * clampu(geo_reg[CFG_IMAGE_HEIGHT], 1, 2048);
		if (n > cap) n = cap;
		for (int unsigned i = 0; i < n; i++) begin
			if (noise && $urandom_range(99) < 3) send(OP_DRAIN, $urandom, $urandom, $urandom);
			send(OP_PIXEL, $urandom, $urandom, $urandom);
		end
		k = cut_drain ? $urandom_range(8) : 1 << 30;
		while (frame_in_done && k > 0) begin
			send(OP_DRAIN, $urandom, $urandom, $urandom);
			k--;
		end
		if (noise && $urandom_range(3) == 0) send(OP_DRAIN, $urandom, $urandom, $urandom);
	endtask

	stim_row_t directed[$] = '{
		'{OP_DRAIN, 8'd7, 8'd7, 8'd7, 0, '{0, 0, 0, 0}},
		'{OP_PIXEL, 8'd255, 8'd0, 8'd1, 0, '{0, 0, 0, 0}},
		'{OP_DRAIN, 8'd0, 8'd0, 8'd0, 0, '{0, 0, 0, 0}},
		'{OP_PIXEL, 8'd255, 8'd0, 8'd1, 0, '{0, 0, 0, 0}},
		'{OP_PIXEL, 8'd255, 8'd0, 8'd0, 0, '{0, 0, 0, 0}},
		'{OP_PIXEL, 8'd255, 8'd255, 8'd0, 0, '{0, 0, 0, 0}},
		'{OP_DRAIN, 8'd0, 8'd0, 8'd0, 1, '{8'd255, 8'd64, 8'd0, 1'b0}},
		'{OP_DRAIN, 8'd0, 8'd0, 8'd0, 1, '{8'd255, 8'd64, 8'd0, 1'b0}},
		'{OP_DRAIN, 8'd0, 8'd0, 8'd0, 1, '{8'd255, 8'd64, 8'd0, 1'b0}},
		'{OP_DRAIN, 8'd0, 8'd0, 8'd0, 1, '{8'd255, 8'd64, 8'd0, 1'b1}},
		'{OP_DRAIN, 8'd0, 8'd0, 8'd0, 0, '{0, 0, 0, 0}},
		'{OP_PIXEL, 8'd1, 8'd2, 8'd3, 0, '{0, 0, 0, 0}},
		'{OP_PIXEL, 8'd5, 8'd1, 8'd0, 0, '{0, 0, 0, 0}},
		'{OP_PIXEL, 8'd0, 8'd1, 8'd3, 0, '{0, 0, 0, 0}},
		'{OP_PIXEL, 8'd0, 8'd0, 8'd2, 0, '{0, 0, 0, 0}},
		'{OP_DRAIN, 8'd0, 8'd0, 8'd0, 1, '{8'd2, 8'd1, 8'd2, 1'b0}}
	};

	initial begin
		int unsigned v[7];
		geo_reg = '{640, 480, 0, 0, 0, 0, 20};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(directed[0].op, directed[0].b, directed[0].g, directed[0].r);
		write_geometry('{2, 2, 0, 0, 1, 1, 2});
		foreach (directed[i]) begin
			if (i == 0) continue;
			send(directed[i].op, directed[i].b, directed[i].g, directed[i].r);
			if (directed[i].typed) begin
				void'(pending_px.pop_back());
				pending_px.push_back(directed[i].want);
			end
		end
		// abandoned frame leaves three pixels undrained; reconfigure drops them
		for (int f = 0; sent < 750; f++) begin
			idle_mode = (f / 3) % 4;
			if (f == 0 || $urandom_range(3) != 0) begin
				v[CFG_IMAGE_WIDTH] = $urandom_range(19) == 0 ? 0 : $urandom_range(1, 12);
				v[CFG_IMAGE_HEIGHT] = $urandom_range(19) == 0 ? 0 : $urandom_range(1, 12);
				v[CFG_REGION_X] = $urandom_range(12) | ($urandom_range(1) << 11);
				v[CFG_REGION_Y] = $urandom_range(12);
				v[CFG_REGION_WIDTH] = $urandom_range(5) == 0 ? 0 : $urandom_range(1, 14);
				v[CFG_REGION_HEIGHT] = $urandom_range(5) == 0 ? 0 : $urandom_range(1, 14);
				v[CFG_BLOCK_SIZE] = $urandom_range(9) == 0 ? 63 : $urandom_range(0, 6);
				write_geometry(v);
			end
			run_frame($urandom_range(7) == 0, 1);
		end
		idle_mode = 0;
		write_geometry('{1, 4095, 0, 2040, 1, 4095, 63});
		run_frame(0, 0, 48);
		write_geometry('{12, 12, 0, 0, 4095, 4095, 63});
		run_frame(0, 0);
		in_valid <= 1'b0;
		wait (pending_px.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
